// ----- src/ssd_pkg.sv -----
// Shared types, codes and glyph helpers for the seven-segment status display.
package ssd_pkg;

  localparam int DIGIT_COUNT = 8;

  localparam logic [1:0] MODE_MAIN     = 2'd0;
  localparam logic [1:0] MODE_SETTINGS = 2'd1;
  localparam logic [1:0] MODE_SCAN     = 2'd2;

  localparam logic [2:0] ACT_SHOW         = 3'd0;
  localparam logic [2:0] ACT_SET_TEMP     = 3'd1;
  localparam logic [2:0] ACT_EDIT_HOURS   = 3'd2;
  localparam logic [2:0] ACT_EDIT_MINUTES = 3'd3;
  localparam logic [2:0] ACT_TEMP_MODE    = 3'd4;
  localparam logic [2:0] ACT_SOUND        = 3'd5;
  localparam logic [2:0] ACT_KEY_SOUND    = 3'd6;
  localparam logic [2:0] ACT_NONE         = 3'd7;

  localparam logic [2:0] REG_MAX_ERRORS     = 3'd0;
  localparam logic [2:0] REG_SETPOINT       = 3'd1;
  localparam logic [2:0] REG_SOUND_OFF      = 3'd2;
  localparam logic [2:0] REG_KEY_SOUND_OFF  = 3'd3;
  localparam logic [2:0] REG_NO_INTERPOLATE = 3'd4;

  localparam logic [7:0] SEG_BLANK      = 8'hFF;
  localparam logic [7:0] SEG_DASH       = 8'hFC;
  localparam logic [7:0] SEG_COLON_MASK = 8'hFE;

  localparam logic [7:0] MASK_SENSOR  = 8'h0F;
  localparam logic [7:0] MASK_TEMP    = 8'h0C;
  localparam logic [7:0] MASK_HOUR    = 8'hC0;
  localparam logic [7:0] MASK_MINUTE  = 8'h30;
  localparam logic [7:0] MASK_INTERP  = 8'h04;
  localparam logic [7:0] MASK_SOUND   = 8'h02;
  localparam logic [7:0] MASK_KEY     = 8'h01;

  localparam logic [3:0] BLINK_PHASE_MAX = 4'd10;

  localparam logic [7:0] GLYPH [10] = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
  };

  typedef struct packed {
    logic [7:0] max_errors;
    logic [7:0] setpoint;
    logic       sound_off;
    logic       key_sound_off;
    logic       no_interpolate;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  action;
    logic [7:0]  sensor_errors;
    logic [7:0]  temperature;
    logic [7:0]  humidity;
    logic [15:0] minutes_left;
    logic [10:0] hours;
    logic [5:0]  seconds_left;
    logic        stopped;
    logic [3:0]  blink_phase;
  } item_t;

  // {tens glyph, units glyph} of the two low decimal digits
  function automatic logic [15:0] seg_pair(input logic [7:0] value);
    logic [15:0] prod_q;
    logic [4:0]  q;
    logic [3:0]  units;
    logic [12:0] prod_t;
    logic [1:0]  t;
    logic [3:0]  tens;
    prod_q = 16'(value) * 16'd205;
    q      = prod_q[15:11];
    units  = 4'(value - {3'b000, q} * 8'd10);
    prod_t = {8'b0, q} * 13'd205;
    t      = prod_t[12:11];
    tens   = 4'(q - {3'b000, t} * 5'd10);
    return {GLYPH[tens], GLYPH[units]};
  endfunction

endpackage

// ----- src/ssd_cfg.sv -----
// APB-style configuration register file.
module ssd_cfg import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_errors     <= 8'd3;
      cfg_r.setpoint       <= 8'd50;
      cfg_r.sound_off      <= 1'b0;
      cfg_r.key_sound_off  <= 1'b0;
      cfg_r.no_interpolate <= 1'b0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_MAX_ERRORS:     cfg_r.max_errors     <= pwdata[7:0];
        REG_SETPOINT:       cfg_r.setpoint       <= pwdata[7:0];
        REG_SOUND_OFF:      cfg_r.sound_off      <= pwdata[0];
        REG_KEY_SOUND_OFF:  cfg_r.key_sound_off  <= pwdata[0];
        REG_NO_INTERPOLATE: cfg_r.no_interpolate <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAX_ERRORS:     prdata = {24'b0, cfg_r.max_errors};
      REG_SETPOINT:       prdata = {24'b0, cfg_r.setpoint};
      REG_SOUND_OFF:      prdata = {31'b0, cfg_r.sound_off};
      REG_KEY_SOUND_OFF:  prdata = {31'b0, cfg_r.key_sound_off};
      REG_NO_INTERPOLATE: prdata = {31'b0, cfg_r.no_interpolate};
      default:            prdata = 32'b0;
    endcase
  end

endmodule

// ----- src/ssd_ingress.sv -----
// Input register stage; splits the countdown into hours by reciprocal multiply.
module ssd_ingress import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_sensor_errors,
  input  logic [7:0]  in_temperature,
  input  logic [7:0]  in_humidity,
  input  logic [15:0] in_minutes_left,
  input  logic [5:0]  in_seconds_left,
  input  logic        in_countdown_stopped,
  input  logic [15:0] in_tick_count,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  logic        valid_r;
  item_t       item_r;
  item_t       item_nxt;
  logic [31:0] hour_prod;
  logic        load;

  assign in_ready   = !valid_r || item_take;
  assign load       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // minutes / 60 is exact for all 16-bit inputs with this reciprocal
  assign hour_prod = 32'(in_minutes_left) * 32'd34953;

  always_comb begin
    item_nxt.mode          = in_mode;
    item_nxt.action        = in_action;
    item_nxt.sensor_errors = in_sensor_errors;
    item_nxt.temperature   = in_temperature;
    item_nxt.humidity      = in_humidity;
    item_nxt.minutes_left  = in_minutes_left;
    item_nxt.hours         = hour_prod[31:21];
    item_nxt.seconds_left  = in_seconds_left;
    item_nxt.stopped       = in_countdown_stopped;
    item_nxt.blink_phase   = in_tick_count[8:5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- src/ssd_core.sv -----
// Digit buffer, blink mask, scan pointer and result register.
module ssd_core import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_segments,
  output logic [7:0] out_digit_select,
  output logic [2:0] out_digit_index
);

  logic [7:0]  digits_r [DIGIT_COUNT];
  logic [7:0]  digits_nxt [DIGIT_COUNT];
  logic [7:0]  main_digits [DIGIT_COUNT];
  logic [7:0]  set_digits [DIGIT_COUNT];
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  scan_pos_r;
  logic        out_valid_r;
  logic [7:0]  out_seg_r, out_sel_r;
  logic [2:0]  out_idx_r;

  logic        is_scan;
  logic        failed;
  logic [15:0] hour_mins;
  logic [15:0] rem_full;
  logic [15:0] hum_pair, temp_pair, target_pair, secs_pair, rem_pair, hour_pair;
  logic [7:0]  scan_seg;

  assign is_scan   = item.mode == MODE_SCAN;
  assign item_take = item_valid && (!is_scan || !out_valid_r || out_ready);

  assign failed    = item.sensor_errors >= cfg.max_errors;
  assign hour_mins = 16'({item.hours, 6'b0}) - 16'({item.hours, 2'b0});
  assign rem_full  = item.minutes_left - hour_mins;

  assign hum_pair    = seg_pair(item.humidity);
  assign temp_pair   = seg_pair(item.temperature);
  assign target_pair = seg_pair(cfg.setpoint);
  assign secs_pair   = seg_pair({2'b00, item.seconds_left});
  assign rem_pair    = seg_pair({2'b00, rem_full[5:0]});
  assign hour_pair   = seg_pair(item.hours[7:0]);

  always_comb begin
    main_digits[0] = failed ? SEG_DASH : hum_pair[7:0];
    main_digits[1] = failed ? SEG_DASH : hum_pair[15:8];
    if (item.action == ACT_SET_TEMP) begin
      main_digits[2] = target_pair[7:0];
      main_digits[3] = target_pair[15:8];
    end else begin
      main_digits[2] = failed ? SEG_DASH : temp_pair[7:0];
      main_digits[3] = failed ? SEG_DASH : temp_pair[15:8];
    end
    if (item.stopped) begin
      main_digits[4] = SEG_DASH;
      main_digits[5] = SEG_DASH;
      main_digits[6] = SEG_DASH;
      main_digits[7] = SEG_DASH;
    end else if (item.minutes_left == 16'd1 && item.action == ACT_SHOW) begin
      main_digits[4] = secs_pair[7:0];
      main_digits[5] = secs_pair[15:8];
      main_digits[6] = SEG_BLANK;
      main_digits[7] = SEG_BLANK;
    end else begin
      main_digits[4] = rem_pair[7:0];
      main_digits[5] = rem_pair[15:8];
      main_digits[6] = hour_pair[7:0];
      main_digits[7] = hour_pair[15:8];
    end
    main_digits[4] = main_digits[4] & SEG_COLON_MASK;
  end

  // sound code 11 less 10 and/or 1: each digit is 1 unless its switch is off
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      set_digits[i] = SEG_BLANK;
    end
    set_digits[0] = cfg.key_sound_off ? GLYPH[0] : GLYPH[1];
    set_digits[1] = cfg.sound_off ? GLYPH[0] : GLYPH[1];
    set_digits[2] = cfg.no_interpolate ? GLYPH[0] : GLYPH[1];
  end

  always_comb begin
    mask_nxt   = mask_r;
    digits_nxt = digits_r;
    case (item.mode)
      MODE_MAIN: begin
        digits_nxt = main_digits;
        case (item.action)
          ACT_SHOW:         mask_nxt = failed ? MASK_SENSOR : 8'h00;
          ACT_SET_TEMP:     mask_nxt = MASK_TEMP;
          ACT_EDIT_HOURS:   mask_nxt = MASK_HOUR;
          ACT_EDIT_MINUTES: mask_nxt = MASK_MINUTE;
          default: ;
        endcase
      end
      MODE_SETTINGS: begin
        digits_nxt = set_digits;
        case (item.action)
          ACT_TEMP_MODE: mask_nxt = MASK_INTERP;
          ACT_SOUND:     mask_nxt = MASK_SOUND;
          ACT_KEY_SOUND: mask_nxt = MASK_KEY;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign scan_seg = (item.blink_phase > BLINK_PHASE_MAX && mask_r[scan_pos_r])
                  ? SEG_BLANK : digits_r[scan_pos_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits_r[i] <= 8'h00;
      end
      mask_r      <= 8'h00;
      scan_pos_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        digits_r <= digits_nxt;
        mask_r   <= mask_nxt;
      end
      if (item_take && is_scan) begin
        scan_pos_r  <= scan_pos_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && is_scan) begin
      out_seg_r <= scan_seg;
      out_sel_r <= 8'd1 << scan_pos_r;
      out_idx_r <= scan_pos_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_seg_r;
  assign out_digit_select = out_sel_r;
  assign out_digit_index  = out_idx_r;

  a_sel_matches_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_sel_r == (8'd1 << out_idx_r))
    else $error("digit select does not match digit index");

  a_scan_advances: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && is_scan |=> scan_pos_r == $past(scan_pos_r) + 3'd1)
    else $error("scan pointer did not advance");

  a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && is_scan |=> out_valid_r && out_idx_r == $past(scan_pos_r))
    else $error("scan transaction produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(item_take && is_scan))
    else $error("pending result overwritten");

endmodule

// ----- src/seven_segment_status_display.sv -----
// Seven-segment status display: buffer refresh and multiplexed digit scan.
// The block accepts one transaction per cycle unless a scan waits behind a
// result held by a stalled receiver; a scan result passes through the input
// register, then the state and result register. Refresh transactions (main
// and settings) rewrite the eight-digit buffer and, for the actions that set
// one, the blink mask, and give no result; mode 3 is ignored. A scan
// transaction returns the current digit's active-low segments, its one-hot
// select and index, then moves to the next digit. A result held by a stalled
// receiver holds back the next scan and every transaction behind it.
module seven_segment_status_display import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_sensor_errors,
  input  logic [7:0]  in_temperature,
  input  logic [7:0]  in_humidity,
  input  logic [15:0] in_minutes_left,
  input  logic [5:0]  in_seconds_left,
  input  logic        in_countdown_stopped,
  input  logic [15:0] in_tick_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_segments,
  output logic [7:0]  out_digit_select,
  output logic [2:0]  out_digit_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_take;

  ssd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssd_ingress u_ingress (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_action            (in_action),
    .in_sensor_errors     (in_sensor_errors),
    .in_temperature       (in_temperature),
    .in_humidity          (in_humidity),
    .in_minutes_left      (in_minutes_left),
    .in_seconds_left      (in_seconds_left),
    .in_countdown_stopped (in_countdown_stopped),
    .in_tick_count        (in_tick_count),
    .item_valid           (item_valid),
    .item                 (item),
    .item_take            (item_take)
  );

  ssd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .item_valid       (item_valid),
    .item             (item),
    .item_take        (item_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_digit_index  (out_digit_index)
  );

endmodule
